[rtl/core/lse_pkg.sv]
package lse_pkg;

  // Default configuration of the extractor.
  localparam int LENGTH_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int COMP_W = 8;

  // Kind of an input component, decided at the front.
  typedef enum logic [0:0] {
    ITEM_DATA    = 1'b0,
    ITEM_RESTART = 1'b1
  } item_kind_t;

  // One classified component as it travels through the queue.
  typedef struct packed {
    item_kind_t        kind;
    logic [COMP_W-1:0] component;
  } item_t;

  // Extraction phase of the back end, one-hot.
  typedef enum logic [4:0] {
    PH_WAIT    = 5'b00001,
    PH_MODE_HI = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

endpackage

[rtl/core/lse_front.sv]
module lse_front (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [lse_pkg::COMP_W-1:0] in_tdata,
  input  logic                      in_tuser,
  output logic                      push,
  output lse_pkg::item_t            push_item,
  input  logic                      q_full
);

  // Accept a component whenever the queue has room.
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // Classify the component: a first flag restarts extraction.
  always_comb begin
    push_item.component = in_tdata;
    if (in_tuser) begin
      push_item.kind = lse_pkg::ITEM_RESTART;
    end else begin
      push_item.kind = lse_pkg::ITEM_DATA;
    end
  end

endmodule

[rtl/core/lse_queue.sv]
module lse_queue #(
  parameter int QUEUE_DEPTH = lse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lse_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lse_pkg::item_t head_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lse_pkg::item_t entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/lse_back.sv]
module lse_back #(
  parameter int LENGTH_BYTES = lse_pkg::LENGTH_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  lse_pkg::item_t             head_item,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lse_pkg::COMP_W-1:0] out_tdata,
  output logic                       out_tlast
);

  localparam int REM_W = 8 * LENGTH_BYTES;
  localparam int CNT_W = $clog2(LENGTH_BYTES + 1);

  lse_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] rem_shifted;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [7:0] chunk;
  logic [3:0] size;
  logic [2:0] shift_w;
  logic [3:0] pos_sum;
  logic [7:0] acc_new;
  logic       complete;
  logic       back_ready;
  logic       rem_is_one;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The back end advances when the output register is free or being drained.
  assign back_ready = !out_valid_r || out_tready;
  assign pop        = head_valid && back_ready;

  // Chunk selection: the low 1, 2, 4 or 8 bits of the component.
  always_comb begin
    unique case (mode_r)
      2'd0: begin
        chunk = head_item.component & 8'b00000001;
        size  = 4'd1;
      end
      2'd1: begin
        chunk = head_item.component & 8'b00000011;
        size  = 4'd2;
      end
      2'd2: begin
        chunk = head_item.component & 8'b00001111;
        size  = 4'd4;
      end
      default: begin
        chunk = head_item.component & 8'b11111111;
        size  = 4'd8;
      end
    endcase
  end

  // Pack the chunk most significant first into the byte being built.
  assign shift_w  = 3'(4'd8 - {1'b0, pos_r} - size);
  assign acc_new  = acc_r | (chunk << shift_w);
  assign pos_sum  = {1'b0, pos_r} + size;
  assign complete = pos_sum[3];

  // Length bytes arrive low byte first, so shift each one in from the top.
  assign rem_shifted = (rem_r >> 8) | (REM_W'(acc_new) << (REM_W - 8));
  assign rem_is_one  = (rem_r == REM_W'(1));

  // Extraction state machine and output register.
  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (pop) begin
      if (head_item.kind == lse_pkg::ITEM_RESTART) begin
        // A first component restarts extraction and gives mode bit 0.
        mode_nxt  = {1'b0, head_item.component[0]};
        pos_nxt   = '0;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        rem_nxt   = '0;
        phase_nxt = lse_pkg::PH_MODE_HI;
      end else begin
        unique case (phase_r)
          lse_pkg::PH_MODE_HI: begin
            mode_nxt  = {head_item.component[0], mode_r[0]};
            phase_nxt = lse_pkg::PH_LENGTH;
          end
          lse_pkg::PH_LENGTH: begin
            acc_nxt = complete ? 8'd0 : acc_new;
            pos_nxt = pos_sum[2:0];
            if (complete) begin
              rem_nxt = rem_shifted;
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == CNT_W'(LENGTH_BYTES - 1)) begin
                phase_nxt = (rem_shifted == '0) ? lse_pkg::PH_DONE : lse_pkg::PH_PAYLOAD;
              end
            end
          end
          lse_pkg::PH_PAYLOAD: begin
            acc_nxt = complete ? 8'd0 : acc_new;
            pos_nxt = pos_sum[2:0];
            if (complete) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = acc_new;
              out_last_nxt  = rem_is_one;
              rem_nxt       = rem_r - 1'b1;
              if (rem_is_one) begin
                phase_nxt = lse_pkg::PH_DONE;
              end
            end
          end
          default: begin
            // Waiting for a first component, or the payload is finished.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lse_pkg::PH_WAIT;
      mode_r      <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[rtl/core/lsb_stego_payload_extractor.sv]
// Extracts a payload hidden in the low bits of an image's colour components.
// Components enter one per transfer on in_tdata, with in_tuser high on the
// first component of each image; the mode bits, the LENGTH_BYTES-byte
// little-endian length and then the payload bytes are pulled from the
// components that follow, and each payload byte leaves as one transfer with
// out_tlast on the final byte. The block takes one component per clock
// cycle while the output is not stalled, since the back end then retires
// one queued component per cycle. Components wait in a queue of
// QUEUE_DEPTH components between the input and the extraction logic, and
// each completed byte sits in an output register, so a stalled output only
// stops the input once the queue fills.
module lsb_stego_payload_extractor #(
  parameter int LENGTH_BYTES = lse_pkg::LENGTH_BYTES_DEF,
  parameter int QUEUE_DEPTH  = lse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] component
  input  logic       in_tuser,   // [0] first
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic       out_tlast
);

  logic           push;
  lse_pkg::item_t push_item;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  lse_pkg::item_t head_item;

  // Front: input handshake and classification.
  lse_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // Queue between front and back.
  lse_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: extraction state machine and output register.
  lse_back #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/core/lse_checker.sv]
module lse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // An offered component holds still until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input changed while waiting");

  // A stalled result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The queue is empty after reset, so input is taken at once.
  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");

  // A new payload needs a restart, mode and length first, so the last byte
  // cannot be followed directly by another byte.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("byte directly after final payload byte");

endmodule

bind lsb_stego_payload_extractor lse_checker u_lse_checker (.*);

[tb/sv/lsb_stego_payload_extractor_test.sv]
`timescale 1ns / 100ps

module lsb_stego_payload_extractor_test;

  localparam int LEN_BYTES   = lse_pkg::LENGTH_BYTES_DEF;
  localparam int ITEM_TARGET = 1750;
  localparam int DRAIN_WAIT  = 64;

  // One expected payload byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_byte_t;

  // Tracks the extraction state and holds the payload bytes still to come.
  class payload_scoreboard;
    lse_pkg::phase_t phase;
    logic [1:0]      mode;
    int              bits_filled;
    logic [7:0]      acc;
    int              len_count;
    logic [63:0]     remaining;
    payload_byte_t   pending_bytes[$];
    int              failures;

    function new();
      phase       = lse_pkg::PH_WAIT;
      mode        = 2'd0;
      bits_filled = 0;
      acc         = 8'd0;
      len_count   = 0;
      remaining   = 64'd0;
      failures    = 0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    // Adds the low chunk of a component to the byte being assembled.
    function bit take_chunk(input logic [7:0] comp, output logic [7:0] done_byte);
      int         size;
      logic [7:0] mask;
      size = 1 << mode;
      mask = (size == 8) ? 8'hFF : 8'((1 << size) - 1);
      acc = acc | ((comp & mask) << (8 - bits_filled - size));
      bits_filled += size;
      done_byte = acc;
      if (bits_filled >= 8) begin
        acc = 8'd0;
        bits_filled = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Notes an accepted component; returns 1 when the block makes use of it.
    function bit absorb_component(input logic [7:0] comp, input logic first);
      logic [7:0] b;
      if (first) begin
        mode        = {1'b0, comp[0]};
        bits_filled = 0;
        acc         = 8'd0;
        len_count   = 0;
        remaining   = 64'd0;
        phase       = lse_pkg::PH_MODE_HI;
        return 1'b1;
      end
      case (phase)
        lse_pkg::PH_MODE_HI: begin
          mode[1] = comp[0];
          phase = lse_pkg::PH_LENGTH;
          return 1'b1;
        end
        lse_pkg::PH_LENGTH: begin
          if (take_chunk(comp, b)) begin
            remaining = remaining | ({56'd0, b} << (len_count * 8));
            len_count++;
            if (len_count >= LEN_BYTES) begin
              phase = (remaining == 64'd0) ? lse_pkg::PH_DONE : lse_pkg::PH_PAYLOAD;
            end
          end
          return 1'b1;
        end
        lse_pkg::PH_PAYLOAD: begin
          if (take_chunk(comp, b)) begin
            pending_bytes.push_back('{data: b, last: (remaining == 64'd1)});
            remaining = remaining - 64'd1;
            if (remaining == 64'd0) begin
              phase = lse_pkg::PH_DONE;
            end
          end
          return 1'b1;
        end
        default: begin
          return 1'b0;
        end
      endcase
    endfunction

    // Compares one output transfer with the oldest expected byte.
    function void check_byte(input logic [7:0] data, input logic last);
      payload_byte_t exp_byte;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected output byte, expected none, actual data %02h last %0b",
                 $time, data, last);
        failures++;
        return;
      end
      exp_byte = pending_bytes.pop_front();
      if (data !== exp_byte.data) begin
        $display("%0t: data mismatch, expected %02h, actual %02h",
                 $time, exp_byte.data, data);
        failures++;
      end
      if (last !== exp_byte.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b",
                 $time, exp_byte.last, last);
        failures++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] component
  logic       in_tuser;   // [0] first
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] data_byte
  logic       out_tlast;

  payload_scoreboard sb;
  logic [8:0]        image_items[$];  // {first, component}
  int                useful_items;
  bit                send_calm;
  bit                recv_calm;

  lsb_stego_payload_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle cycles before a transfer, with occasional runs of none at all.
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Offers one component and waits for its transfer.
  task automatic send_component(input logic [7:0] comp, input logic first);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      send_calm = !send_calm;
    end
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= comp;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    if (sb.absorb_component(comp, first)) begin
      useful_items++;
    end
  endtask

  // Splits a byte into chunks for the given mode, with random upper bits.
  task automatic encode_byte(input logic [7:0] value, input logic [1:0] mode);
    int         size;
    logic [7:0] mask;
    logic [7:0] chunk;
    logic [7:0] noise;
    size = 1 << mode;
    mask = (size == 8) ? 8'hFF : 8'((1 << size) - 1);
    for (int k = 0; k < 8 / size; k++) begin
      chunk = (value >> (8 - (k + 1) * size)) & mask;
      noise = 8'($urandom);
      image_items.push_back({1'b0, (noise & ~mask) | chunk});
    end
  endtask

  // Lays out one image: mode components, length, payload and trailing noise.
  task automatic build_image(input logic [1:0] mode, input logic [63:0] length,
                             input int payload_n, input int trailer_n);
    logic [7:0] noise;
    image_items.delete();
    noise = 8'($urandom);
    image_items.push_back({1'b1, noise[7:1], mode[0]});
    noise = 8'($urandom);
    image_items.push_back({1'b0, noise[7:1], mode[1]});
    for (int i = 0; i < LEN_BYTES; i++) begin
      encode_byte(length[8*i +: 8], mode);
    end
    for (int i = 0; i < payload_n; i++) begin
      encode_byte(8'($urandom), mode);
    end
    for (int i = 0; i < trailer_n; i++) begin
      image_items.push_back({1'b0, 8'($urandom)});
    end
  endtask

  task automatic send_image_items();
    foreach (image_items[i]) begin
      send_component(image_items[i][7:0], image_items[i][8]);
    end
  endtask

  // Withdraws the input and waits until every expected byte has left.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: random stalls, every transfer checked.
  initial begin
    int stall;
    out_tready <= 1'b0;
    recv_calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) begin
        recv_calm = !recv_calm;
      end
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_byte(out_tdata, out_tlast);
    end
  end

  // Reset, directed images, random images, then the drain.
  initial begin
    logic [1:0]  mode;
    logic [63:0] length;
    int          payload_n;
    int          trailer_n;
    int          pick;
    int          cut;
    sb = new();
    useful_items = 0;
    send_calm = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tuser  <= 1'b0;
    rst_n     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Components before any image start are dropped.
    send_component(8'hFF, 1'b0);
    send_component(8'h00, 1'b0);
    // Whole-byte chunks, a one-byte payload, then a component after the end.
    build_image(2'd3, 64'd1, 1, 1);
    send_image_items();
    // Zero length emits nothing and ignores what follows.
    build_image(2'd3, 64'd0, 0, 1);
    send_image_items();
    wait_for_drain();

    while (useful_items < ITEM_TARGET) begin
      mode = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        length = 64'd0;
        payload_n = 0;
      end else if (pick < 16) begin
        // Huge length: the image ends long before the payload does.
        length = {$urandom, $urandom};
        payload_n = $urandom_range(0, 16);
      end else if (pick < 19) begin
        mode = 2'd3;
        length = 64'($urandom_range(256, 300));
        payload_n = int'(length);
      end else begin
        length = 64'($urandom_range(1, 24));
        payload_n = int'(length);
      end
      trailer_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      build_image(mode, length, payload_n, trailer_n);
      // Now and then the next image start cuts this one short.
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, image_items.size() - 1);
        while (image_items.size() > cut) void'(image_items.pop_back());
      end
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 4)) send_component(8'($urandom), 1'b0);
      end
      send_image_items();
      if ($urandom_range(0, 9) == 0) begin
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lse_pkg.sv
rtl/core/lse_front.sv
rtl/core/lse_queue.sv
rtl/core/lse_back.sv
rtl/core/lsb_stego_payload_extractor.sv
rtl/core/lse_checker.sv
tb/sv/lsb_stego_payload_extractor_test.sv
